FILE: rtl/camera_control_frame_parser_macros.svh
// assertion macros for the camera control frame parser checker
// no dependencies; included by files that hold concurrent assertions
`ifndef CAMERA_CONTROL_FRAME_PARSER_MACROS_SVH
`define CAMERA_CONTROL_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CCFP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, disabled while reset is high
`define CCFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: rtl/ccfp_pkg.sv
// types, constants and helpers shared by the camera control frame parser
// no dependencies
`default_nettype none

package ccfp_pkg;

   localparam int MAX_BODY_DEFAULT = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int BODY_LEN_W       = 5;
   localparam int POS_W            = 3;

   localparam logic [7:0] ADDR_HIGH_MASK = 8'hF0;
   localparam logic [7:0] ADDR_PREFIX    = 8'h80;
   localparam logic [7:0] ADDR_LOW_MASK  = 8'h0F;
   localparam logic [7:0] TERMINATOR     = 8'hFF;
   localparam logic [3:0] BROADCAST_DEST = 4'd8;

   // frame positions; the counter saturates at the body position
   localparam logic [POS_W-1:0] POS_ADDRESS  = 3'd0;
   localparam logic [POS_W-1:0] POS_CLASS    = 3'd1;
   localparam logic [POS_W-1:0] POS_CATEGORY = 3'd2;
   localparam logic [POS_W-1:0] POS_COMMAND  = 3'd3;
   localparam logic [POS_W-1:0] POS_BODY     = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic                  is_body;
      logic                  ok;
      logic [3:0]            destination;
      logic [7:0]            class_byte;
      logic [7:0]            category_byte;
      logic [7:0]            command_byte;
      logic [BODY_LEN_W-1:0] body_length;
      logic [7:0]            body_byte;
      logic                  last;
   } rsp_type;

   // verdict handed from the parser to the output side
   typedef struct packed {
      logic       ok;
      logic [3:0] destination;
      logic [7:0] class_byte;
      logic [7:0] category_byte;
      logic [7:0] command_byte;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VERDICT,
      ST_READ,
      ST_BODY
   } back_state_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/camera_control_frame_parser.sv
// camera control command frame parser, one request byte per cycle
// a verdict is registered in the queue, then in the sequencer's payload, before it shows
// body bytes follow one by one, each read from the registered ram after the last is taken
// requests flow one per cycle, held back only while the queue is full or a body
// readout blocks requests at the body position; synchronous reset clears the parser,
// queue and sequencer at once, the body ram is not cleared
`default_nettype none

module camera_control_frame_parser
   import ccfp_pkg::*;
#(
   parameter int MAX_BODY = MAX_BODY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int CNT_W = $clog2(MAX_BODY + 1);
   localparam int AW    = addr_width(MAX_BODY);
   localparam int QW    = $bits(job_type) + CNT_W;

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;
   job_type          push_job;
   job_type          head_job;
   logic [CNT_W-1:0] push_count;
   logic [CNT_W-1:0] head_count;
   logic [QW-1:0]    head_data;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_data;
   logic             body_done;

   ccfp_front #(
      .MAX_BODY (MAX_BODY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job),
      .q_count     (push_count),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .body_done   (body_done)
   );

   ccfp_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_job, push_count}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_data (head_data)
   );

   assign head_job   = head_data[QW-1:CNT_W];
   assign head_count = head_data[CNT_W-1:0];

   ccfp_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BODY)
   ) u_body_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ccfp_back #(
      .MAX_BODY (MAX_BODY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_job       (head_job),
      .q_count     (head_count),
      .q_pop       (q_pop),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .body_done   (body_done)
   );

endmodule

`default_nettype wire

FILE: rtl/ccfp_ram.sv
// simple dual-port ram, one write and one registered read port
// depends on ccfp_pkg
`default_nettype none

module ccfp_ram
   import ccfp_pkg::*;
#(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = MAX_BODY_DEFAULT,
   localparam int AW    = addr_width(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ccfp_queue.sv
// short verdict queue between the parser and the output sequencer
// depends on ccfp_pkg
`default_nettype none

module ccfp_queue
   import ccfp_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic      [WIDTH-1:0] head_data
);

   localparam int PTR_W  = addr_width(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign valid     = (fill_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: rtl/ccfp_front.sv
// request side: parses the frame byte by byte, stores body bytes, queues verdicts
// depends on ccfp_pkg
`default_nettype none

module ccfp_front
   import ccfp_pkg::*;
#(
   parameter  int MAX_BODY = MAX_BODY_DEFAULT,
   localparam int CNT_W    = $clog2(MAX_BODY + 1),
   localparam int AW       = addr_width(MAX_BODY)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_payload,
   input  wire logic             q_full,
   output logic                  q_push,
   output job_type               q_job,
   output logic      [CNT_W-1:0] q_count,
   output logic                  wr_en,
   output logic      [AW-1:0]    wr_addr,
   output logic      [7:0]       wr_data,
   input  wire logic             body_done
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       nibble_ff, nibble_in;
   logic [7:0]       class_ff, class_in;
   logic [7:0]       category_ff, category_in;
   logic [7:0]       command_ff, command_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic             verdict_ff, verdict_in;
   logic             pending_ff, pending_in;
   logic             accept;
   logic             active;
   logic [7:0]       b;

   function automatic logic [3:0] dest_of(input logic [7:0] value);
      logic [3:0] d;
      d = value[3:0] & ADDR_LOW_MASK[3:0];
      if ((value & ADDR_HIGH_MASK) != ADDR_PREFIX) begin
         return '0;
      end
      if (d == '0 || d > BROADCAST_DEST) begin
         return '0;
      end
      return d;
   endfunction

   assign active = !verdict_ff;
   assign b      = req_payload.data_byte;

   // a previous body is still being read out, so no body writes may land yet
   assign req_ready = !q_full && !(active && pos_ff == POS_BODY && pending_ff);
   assign accept    = req_valid && req_ready;

   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = b;

   always_comb begin
      pos_in      = pos_ff;
      nibble_in   = nibble_ff;
      class_in    = class_ff;
      category_in = category_ff;
      command_in  = command_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      verdict_in  = verdict_ff;
      pending_in  = pending_ff;
      q_push      = 1'b0;
      q_job       = '0;
      q_count     = '0;
      wr_en       = 1'b0;

      if (body_done) begin
         pending_in = 1'b0;
      end

      if (accept) begin
         if (active) begin
            if (pos_ff == POS_ADDRESS) begin
               nibble_in = dest_of(b);
            end else if (b == TERMINATOR) begin
               verdict_in = 1'b1;
               q_push     = 1'b1;
               if (nibble_ff != '0 && pos_ff >= POS_CATEGORY && !overflow_ff) begin
                  q_job.ok            = 1'b1;
                  q_job.destination   = nibble_ff;
                  q_job.class_byte    = class_ff;
                  q_job.category_byte = category_ff;
                  q_job.command_byte  = command_ff;
                  q_count             = count_ff;
                  if (count_ff != '0) begin
                     pending_in = 1'b1;
                  end
               end
            end else if (pos_ff == POS_CLASS) begin
               class_in = b;
            end else if (pos_ff == POS_CATEGORY) begin
               category_in = b;
            end else if (pos_ff == POS_COMMAND) begin
               command_in = b;
            end else if (count_ff < CNT_W'(MAX_BODY)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
            if (pos_ff != POS_BODY) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end

         if (req_payload.buffer_end) begin
            // no terminator seen in this buffer: failure verdict
            if (!verdict_in) begin
               q_push  = 1'b1;
               q_job   = '0;
               q_count = '0;
            end
            pos_in      = POS_ADDRESS;
            nibble_in   = '0;
            class_in    = '0;
            category_in = '0;
            command_in  = '0;
            count_in    = '0;
            overflow_in = 1'b0;
            verdict_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_ADDRESS;
         nibble_ff   <= '0;
         class_ff    <= '0;
         category_ff <= '0;
         command_ff  <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         verdict_ff  <= 1'b0;
         pending_ff  <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         nibble_ff   <= nibble_in;
         class_ff    <= class_in;
         category_ff <= category_in;
         command_ff  <= command_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         verdict_ff  <= verdict_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ccfp_back.sv
// response side: presents each verdict, then reads the body bytes out of the ram
// depends on ccfp_pkg
`default_nettype none

module ccfp_back
   import ccfp_pkg::*;
#(
   parameter  int MAX_BODY = MAX_BODY_DEFAULT,
   localparam int CNT_W    = $clog2(MAX_BODY + 1),
   localparam int AW       = addr_width(MAX_BODY)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire job_type          q_job,
   input  wire logic [CNT_W-1:0] q_count,
   output logic                  q_pop,
   output logic                  rd_en,
   output logic      [AW-1:0]    rd_addr,
   input  wire logic [7:0]       rd_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_payload,
   output logic                  body_done
);

   back_state_type   state_ff, state_in;
   rsp_type          rsp_ff;
   logic [CNT_W-1:0] len_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             last_byte;

   assign last_byte = (idx_ff + CNT_W'(1)) == len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_VERDICT;
            end
         end
         ST_VERDICT: begin
            if (rsp_ready) begin
               state_in = (len_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_BODY;
         end
         ST_BODY: begin
            if (rsp_ready) begin
               state_in = last_byte ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rsp_valid = 1'b0;
      body_done = 1'b0;
      idx_in    = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
         end
         ST_VERDICT: begin
            rsp_valid = 1'b1;
            if (rsp_ready && len_ff != '0) begin
               rd_en  = 1'b1;
               idx_in = '0;
            end
         end
         ST_READ: begin
         end
         ST_BODY: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_byte) begin
                  body_done = 1'b1;
               end else begin
                  rd_en  = 1'b1;
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = idx_in[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers; verdict fields carry over onto the body bytes
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (state_ff == ST_IDLE && q_valid) begin
         len_ff                <= q_count;
         rsp_ff.is_body        <= 1'b0;
         rsp_ff.ok             <= q_job.ok;
         rsp_ff.destination    <= q_job.destination;
         rsp_ff.class_byte     <= q_job.class_byte;
         rsp_ff.category_byte  <= q_job.category_byte;
         rsp_ff.command_byte   <= q_job.command_byte;
         rsp_ff.body_length    <= BODY_LEN_W'(q_count);
         rsp_ff.body_byte      <= '0;
         rsp_ff.last           <= (q_count == '0);
      end else if (state_ff == ST_READ) begin
         rsp_ff.is_body   <= 1'b1;
         rsp_ff.body_byte <= rd_data;
         rsp_ff.last      <= last_byte;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ccfp_checker.sv
// port-level checks on the frame parser responses, bound to the top level
// depends on ccfp_pkg and camera_control_frame_parser_macros.svh
`default_nettype none

`include "camera_control_frame_parser_macros.svh"

module ccfp_checker
   import ccfp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   logic req_fire;
   logic rsp_stall;
   logic fail_shape;
   logic dest_legal;

   // a request byte must carry a defined end mark when taken
   assign req_fire = req_valid && req_ready && (req_payload.buffer_end == 1'b0 ||
                                                req_payload.buffer_end == 1'b1);

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign fail_shape = rsp_payload.last && !rsp_payload.is_body &&
                       rsp_payload.destination == 4'd0 && rsp_payload.body_length == '0;
   assign dest_legal = rsp_payload.destination != 4'd0 &&
                       rsp_payload.destination <= BROADCAST_DEST;

   // a stalled response keeps its payload
   `CCFP_ASSERT_NEXT(rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // body bytes only ever follow a good verdict
   `CCFP_ASSERT_NOW(body_only_ok, clock, reset, rsp_valid && rsp_payload.is_body, rsp_payload.ok)

   // a failure verdict is a single zeroed response
   `CCFP_ASSERT_NOW(fail_zeroed, clock, reset, rsp_valid && !rsp_payload.ok, fail_shape)

   // a good verdict names a real destination
   `CCFP_ASSERT_NOW(ok_dest, clock, reset, rsp_valid && rsp_payload.ok, dest_legal)

   // a response cannot appear in the cycle right after reset is released
   `CCFP_ASSERT_NOW(no_early_rsp, clock, reset, $fell(reset) && !req_fire, !rsp_valid)

endmodule

bind camera_control_frame_parser ccfp_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
